[rtl/eec_pkg.sv]
// ----------------------------------------------------------------------------
// eec_pkg
// Shared types and constants for the eight-bit CPU execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

package eec_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned Depth  = 64;
  localparam int unsigned PcW    = 16;
  localparam int unsigned StatW  = 5;

  typedef enum logic [3:0] {
    OpAdd  = 4'd0,
    OpSub  = 4'd1,
    OpMul  = 4'd2,
    OpMovi = 4'd3,
    OpBeqz = 4'd4,
    OpAndi = 4'd5,
    OpEor  = 4'd6,
    OpBr   = 4'd7,
    OpSal  = 4'd8,
    OpSar  = 4'd9,
    OpLdr  = 4'd10,
    OpStr  = 4'd11
  } eec_op_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } eec_wr_t;

  typedef struct packed {
    logic [PcW-1:0]   next_pc;
    logic             pc_changed;
    logic             reg_written;
    logic [DataW-1:0] write_value;
    logic             mem_written;
    logic [StatW-1:0] status;
    logic             bad;
  } eec_res_t;

endpackage

`default_nettype wire

[rtl/eec_ram.sv]
// ----------------------------------------------------------------------------
// eec_ram
// Byte memory with one write port and one registered read port, per-entry
// valid bits so unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_ram (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           rd_en_i,
  input  wire  [eec_pkg::AddrW-1:0]     rd_addr_i,
  input  wire  eec_pkg::eec_wr_t        wr_i,
  output logic [eec_pkg::DataW-1:0]     rd_data_o
);

  logic [eec_pkg::DataW-1:0] mem [eec_pkg::Depth];
  logic [eec_pkg::Depth-1:0] vld_q;
  logic [eec_pkg::DataW-1:0] data_q;
  logic [eec_pkg::DataW-1:0] fwd_q;
  logic                      hit_q;
  logic                      ent_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      data_q <= mem[rd_addr_i];
      fwd_q  <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      hit_q     <= 1'b0;
      ent_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        // A write landing on the same edge is not yet in the array.
        hit_q     <= wr_i.en && (wr_i.addr == rd_addr_i);
        ent_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = hit_q ? fwd_q : (ent_vld_q ? data_q : '0);

endmodule

`default_nettype wire

[rtl/eec_alu.sv]
// ----------------------------------------------------------------------------
// eec_alu
// Instruction decode, ALU and branch target logic for one instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module eec_alu (
  input  wire  eec_pkg::eec_op_e           op_i,
  input  wire  [eec_pkg::AddrW-1:0]        imm_i,
  input  wire  [eec_pkg::PcW-1:0]          pc_i,
  input  wire  [eec_pkg::DataW-1:0]        a_i,
  input  wire  [eec_pkg::DataW-1:0]        b_i,
  input  wire  [eec_pkg::DataW-1:0]        ld_i,
  input  wire  [eec_pkg::StatW-1:0]        status_i,
  output eec_pkg::eec_res_t                res_o
);

  logic [eec_pkg::DataW:0]     sum;
  logic [eec_pkg::DataW-1:0]   diff;
  logic [eec_pkg::DataW-1:0]   prod;
  logic [eec_pkg::DataW-1:0]   sal;
  logic [eec_pkg::DataW-1:0]   sar;
  logic [2:0]                  sar_sh;
  logic                        add_v;
  logic                        sub_v;

  assign sum    = {1'b0, a_i} + {1'b0, b_i};
  assign diff   = a_i - b_i;
  assign prod   = a_i * b_i;
  assign sal    = (imm_i[5:3] != 3'd0) ? '0 : (a_i << imm_i[2:0]);
  assign sar_sh = (imm_i[5:3] != 3'd0) ? 3'd7 : imm_i[2:0];
  assign sar    = $unsigned($signed(a_i) >>> sar_sh);
  assign add_v  = (a_i[7] == b_i[7]) && (sum[7] != a_i[7]);
  assign sub_v  = (a_i[7] != b_i[7]) && (diff[7] != a_i[7]);

  always_comb begin
    res_o         = '0;
    res_o.next_pc = pc_i;
    res_o.status  = status_i;
    unique case (op_i)
      eec_pkg::OpAdd: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = sum[7:0];
        res_o.status      = {sum[8], add_v, sum[7], sum[7] ^ add_v, sum[7:0] == '0};
      end
      eec_pkg::OpSub: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = diff;
        res_o.status      = {1'b0, sub_v, diff[7], diff[7] ^ sub_v, diff == '0};
      end
      eec_pkg::OpMul: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = prod[7:0];
        res_o.status      = {2'b00, prod[7], 1'b0, prod[7:0] == '0};
      end
      eec_pkg::OpMovi: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = {2'b00, imm_i};
      end
      eec_pkg::OpBeqz: begin
        if (a_i == '0) begin
          res_o.pc_changed = 1'b1;
          res_o.next_pc    = pc_i + {10'd0, imm_i};
        end
      end
      eec_pkg::OpAndi: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = a_i & {2'b00, imm_i};
        res_o.status      = {2'b00, 1'b0, 1'b0, (a_i & {2'b00, imm_i}) == '0};
      end
      eec_pkg::OpEor: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = a_i ^ b_i;
        res_o.status      = {2'b00, a_i[7] ^ b_i[7], 1'b0, a_i == b_i};
      end
      eec_pkg::OpBr: begin
        res_o.pc_changed = 1'b1;
        res_o.next_pc    = {a_i, b_i};
      end
      eec_pkg::OpSal: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = sal;
        res_o.status      = {2'b00, sal[7], 1'b0, sal == '0};
      end
      eec_pkg::OpSar: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = sar;
        res_o.status      = {2'b00, sar[7], 1'b0, sar == '0};
      end
      eec_pkg::OpLdr: begin
        res_o.reg_written = 1'b1;
        res_o.write_value = ld_i;
      end
      eec_pkg::OpStr: begin
        res_o.mem_written = 1'b1;
      end
      default: begin
        res_o.bad = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/eight_bit_cpu_execute_stage.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_stage
// Execute stage of an eight-bit Harvard CPU with register file, data memory
// and status register.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o   | instr_word_i, fetch_pc_i
//   out     | out_valid_o / out_ready_i | next_pc_o, pc_changed_o,
//           |                           | reg_written_o, write_value_o,
//           |                           | mem_written_o, status_bits_o,
//           |                           | bad_opcode_o
//
// One instruction is accepted per cycle unless a stalled output register
// holds the stage. The accept edge issues the reads of both register file
// banks and of the data memory; the edge on which the instruction leaves the
// execute stage executes it, writes back and loads the output register, which
// presents the result beat. The registered memory read is why the instruction
// waits in the execute stage. Reset clears per-entry valid bits at once, so
// no clearing pass is needed. A stalled output register holds the execute stage, which holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_cpu_execute_stage (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [15:0]                      instr_word_i,
  input  wire  [eec_pkg::PcW-1:0]          fetch_pc_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [eec_pkg::PcW-1:0]          next_pc_o,
  output logic                             pc_changed_o,
  output logic                             reg_written_o,
  output logic signed [eec_pkg::DataW-1:0] write_value_o,
  output logic                             mem_written_o,
  output logic [eec_pkg::StatW-1:0]        status_bits_o,
  output logic                             bad_opcode_o
);

  // Execute stage registers. The instruction waits here while its operands
  // come out of the memories.
  logic                        s1_vld_q;
  eec_pkg::eec_op_e            s1_op_q;
  logic [eec_pkg::AddrW-1:0]   s1_rs_q;
  logic [eec_pkg::AddrW-1:0]   s1_imm_q;
  logic [eec_pkg::PcW-1:0]     s1_pc_q;

  logic [eec_pkg::StatW-1:0]   status_q;
  logic                        out_vld_q;
  eec_pkg::eec_res_t           out_q;

  logic                        in_acc;
  logic                        s1_adv;
  logic                        s1_fire;
  logic [eec_pkg::DataW-1:0]   op_a;
  logic [eec_pkg::DataW-1:0]   op_b;
  logic [eec_pkg::DataW-1:0]   ld_data;
  eec_pkg::eec_res_t           res;
  eec_pkg::eec_wr_t            rf_wr;
  eec_pkg::eec_wr_t            dm_wr;

  // The execute stage moves on whenever the output register is free or
  // drained in this cycle; a new beat enters whenever the stage moves on.
  assign s1_adv     = !out_vld_q || out_ready_i;
  assign s1_fire    = s1_vld_q && s1_adv;
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // Write-back happens at the edge the instruction leaves the execute stage.
  // The memories forward that write to a read issued on the same edge.
  assign rf_wr.en   = s1_fire && res.reg_written;
  assign rf_wr.addr = s1_rs_q;
  assign rf_wr.data = res.write_value;

  assign dm_wr.en   = s1_fire && res.mem_written;
  assign dm_wr.addr = s1_imm_q;
  assign dm_wr.data = op_a;

  // The register file is two banks written alike, one per read operand.
  eec_ram u_rf_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (instr_word_i[11:6]),
    .wr_i      (rf_wr),
    .rd_data_o (op_a)
  );

  eec_ram u_rf_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (instr_word_i[5:0]),
    .wr_i      (rf_wr),
    .rd_data_o (op_b)
  );

  // Only the 64 entries an immediate can reach are ever addressed.
  eec_ram u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (instr_word_i[5:0]),
    .wr_i      (dm_wr),
    .rd_data_o (ld_data)
  );

  eec_alu u_alu (
    .op_i     (s1_op_q),
    .imm_i    (s1_imm_q),
    .pc_i     (s1_pc_q),
    .a_i      (op_a),
    .b_i      (op_b),
    .ld_i     (ld_data),
    .status_i (status_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= eec_pkg::eec_op_e'(instr_word_i[15:12]);
      s1_rs_q  <= instr_word_i[11:6];
      s1_imm_q <= instr_word_i[5:0];
      s1_pc_q  <= fetch_pc_i;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      status_q  <= '0;
    end else begin
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_vld_q <= s1_vld_q;
      end
      if (s1_fire) begin
        status_q <= res.status;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign next_pc_o     = out_q.next_pc;
  assign pc_changed_o  = out_q.pc_changed;
  assign reg_written_o = out_q.reg_written;
  assign write_value_o = $signed(out_q.write_value);
  assign mem_written_o = out_q.mem_written;
  assign status_bits_o = out_q.status;
  assign bad_opcode_o  = out_q.bad;

`ifndef ASSERT_OFF
  a_ready_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a full, blocked pipeline");

  a_fire_fills_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_vld_q)
    else $error("executed instruction did not reach the output register");

  a_status_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(status_q))
    else $error("status register changed without an executed instruction");

  a_bad_no_effect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_opcode_o) |->
      (!reg_written_o && !mem_written_o && !pc_changed_o))
    else $error("unused opcode caused a side effect");

  a_wb_single_target : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_wr.en && dm_wr.en))
    else $error("register file and data memory written together");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-bit CPU execute stage. A directed table
// walks every opcode and the corner cases of the ALU, branches and memory,
// then about a thousand random instructions follow. Every result beat is
// compared field by field against an in-bench execution model or its pinned table value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes 12 to 15 are not in the package enum; they must do nothing.
  localparam logic [3:0] OpSpareLo = 4'd12;
  localparam logic [3:0] OpSpareHi = 4'd15;

  // Status register layout is {C, V, N, S, Z}.
  localparam logic [eec_pkg::StatW-1:0] FlagZ = 5'b00001;

  localparam int unsigned RandomItems   = 1025;
  localparam int unsigned BurstFirst    = 300;
  localparam int unsigned BurstLast     = 550;
  localparam int unsigned HoldOffAt     = 700;
  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned PrintLimit    = 40;

  typedef struct {
    logic [15:0]             word;
    logic [eec_pkg::PcW-1:0] pc;
    logic                    pinned;
    eec_pkg::eec_res_t       want;
  } dir_row_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  logic                          in_ready;
  logic [15:0]                   instr_word  = '0;
  logic [eec_pkg::PcW-1:0]       fetch_pc    = '0;
  logic                          out_valid;
  logic                          out_ready   = 1'b0;
  logic [eec_pkg::PcW-1:0]       next_pc;
  logic                          pc_changed;
  logic                          reg_written;
  logic [eec_pkg::DataW-1:0]     write_value;
  logic                          mem_written;
  logic [eec_pkg::StatW-1:0]     status_bits;
  logic                          bad_opcode;

  // Shared between the sender and the receiver processes.
  bit burst_mode;      // neither side idles while this is set
  bit sink_hold_req;   // asks the receiver for one long hold-off
  bit sink_holding;    // the receiver is in its hold-off right now

  // Execution model state. The 6-bit immediate reaches all of the 64 bytes
  // of data memory, so all of them are modeled.
  logic [eec_pkg::DataW-1:0] regs_model [eec_pkg::Depth];
  logic [eec_pkg::DataW-1:0] dmem_model [64];
  logic [eec_pkg::StatW-1:0] flags_model;

  eec_pkg::eec_res_t outcome_q [$];
  dir_row_t directed_q [$];

  int unsigned issued_cnt, checked_cnt, taken_cnt, spare_cnt, mismatch_cnt;
  int unsigned quiet_cycles;

  eight_bit_cpu_execute_stage DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .instr_word_i  (instr_word),
    .fetch_pc_i    (fetch_pc),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .next_pc_o     (next_pc),
    .pc_changed_o  (pc_changed),
    .reg_written_o (reg_written),
    .write_value_o (write_value),
    .mem_written_o (mem_written),
    .status_bits_o (status_bits),
    .bad_opcode_o  (bad_opcode)
  );

  // 125 MHz clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Reset is held low at the start and released once, synchronously to the clock.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [15:0] encode(input logic [3:0] op, input logic [5:0] rs,
                                         input logic [5:0] imm);
    return {op, rs, imm};
  endfunction

  function automatic eec_pkg::eec_res_t outcome(input logic [eec_pkg::PcW-1:0] npc,
                                                input logic pcc, input logic rw,
                                                input logic [eec_pkg::DataW-1:0] wv,
                                                input logic mw,
                                                input logic [eec_pkg::StatW-1:0] st,
                                                input logic bad);
    eec_pkg::eec_res_t r;
    r.next_pc     = npc;
    r.pc_changed  = pcc;
    r.reg_written = rw;
    r.write_value = wv;
    r.mem_written = mw;
    r.status      = st;
    r.bad         = bad;
    return r;
  endfunction

  // Executes one instruction against the model state and returns the beat
  // the stage should produce for it. Both operands are read before the
  // write-back, so rs equal to rt sees the old value twice.
  function automatic eec_pkg::eec_res_t execute_instr(input logic [15:0] word,
                                                      input logic [eec_pkg::PcW-1:0] pc);
    eec_pkg::eec_res_t         r;
    logic [3:0]                op;
    logic [5:0]                rs, imm;
    logic [eec_pkg::DataW-1:0] a, b, res;
    logic [8:0]                sum;
    logic                      n, v;
    logic [2:0]                shamt;
    op  = word[15:12];
    rs  = word[11:6];
    imm = word[5:0];
    a   = regs_model[rs];
    b   = regs_model[imm];
    res = '0;
    r   = outcome(pc, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0);
    case (op)
      eec_pkg::OpAdd: begin
        sum = {1'b0, a} + {1'b0, b};
        res = sum[7:0];
        n   = res[7];
        v   = (a[7] == b[7]) && (res[7] != a[7]);
        flags_model   = {sum[8], v, n, n ^ v, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpSub: begin
        res = a - b;
        n   = res[7];
        // Overflow only when the operand signs differ and the result left
        // the sign of the minuend.
        v   = (a[7] != b[7]) && (res[7] != a[7]);
        flags_model   = {1'b0, v, n, n ^ v, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpMul: begin
        res = a * b;
        flags_model   = {2'b00, res[7], 1'b0, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpMovi: begin
        res = {2'b00, imm};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpBeqz: begin
        if (a == 8'h00) begin
          r.next_pc    = pc + {10'd0, imm};
          r.pc_changed = 1'b1;
        end
      end
      eec_pkg::OpAndi: begin
        res = a & {2'b00, imm};
        flags_model   = {2'b00, res[7], 1'b0, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpEor: begin
        res = a ^ b;
        flags_model   = {2'b00, res[7], 1'b0, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpBr: begin
        r.next_pc    = {a, b};
        r.pc_changed = 1'b1;
      end
      eec_pkg::OpSal: begin
        res = (imm >= 6'd8) ? 8'h00 : 8'(a << imm[2:0]);
        flags_model   = {2'b00, res[7], 1'b0, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpSar: begin
        // Long arithmetic shifts saturate at seven: all sign bits.
        shamt = (imm >= 6'd8) ? 3'd7 : imm[2:0];
        res   = $signed(a) >>> shamt;
        flags_model   = {2'b00, res[7], 1'b0, res == 8'h00};
        r.reg_written = 1'b1;
      end
      eec_pkg::OpLdr: begin
        res = dmem_model[imm];
        r.reg_written = 1'b1;
      end
      eec_pkg::OpStr: begin
        dmem_model[imm] = a;
        r.mem_written   = 1'b1;
      end
      default: begin
        r.bad = 1'b1;
      end
    endcase
    if (r.reg_written) begin
      regs_model[rs] = res;
      r.write_value  = res;
    end
    r.status = flags_model;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PrintLimit) begin
      $display("ERROR beat %0d at %0t: %s", checked_cnt, $realtime, msg);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Offers one instruction beat and waits for it to be taken. Idle cycles
  // come before the beat, so valid is never dropped and raised in one step.
  task automatic issue_instr(input logic [15:0] word, input logic [eec_pkg::PcW-1:0] pc,
                             input logic pinned, input eec_pkg::eec_res_t want);
    eec_pkg::eec_res_t predicted;
    while (!burst_mode && !sink_holding && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    instr_word <= word;
    fetch_pc   <= pc;
    do @(posedge clk); while (!in_ready);
    // The model always steps so its state stays in line; a pinned row
    // substitutes the value that can be read straight off the spec.
    predicted = execute_instr(word, pc);
    outcome_q.push_back(pinned ? want : predicted);
    issued_cnt++;
    if (predicted.pc_changed) taken_cnt++;
    if (predicted.bad) spare_cnt++;
  endtask

  // Receiver: random backpressure, except during burst mode and one long
  // hold-off that lets the stage fill up and stall its input.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_holding  = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        sink_holding  = 1'b0;
      end else begin
        out_ready <= burst_mode || ($urandom_range(99) >= 37);
      end
    end
  end

  // Result checker: every accepted beat must match the oldest outcome.
  always @(posedge clk) begin : check_blk
    eec_pkg::eec_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result beat with no instruction outstanding");
      end else begin
        want = outcome_q.pop_front();
        compare_field("next_pc", next_pc, want.next_pc);
        compare_field("pc_changed", 16'(pc_changed), 16'(want.pc_changed));
        compare_field("reg_written", 16'(reg_written), 16'(want.reg_written));
        compare_field("write_value", 16'(write_value), 16'(want.write_value));
        compare_field("mem_written", 16'(mem_written), 16'(want.mem_written));
        compare_field("status_bits", 16'(status_bits), 16'(want.status));
        compare_field("bad_opcode", 16'(bad_opcode), 16'(want.bad));
      end
      checked_cnt++;
    end
  end

  // Watchdog: a long run of cycles without any beat on either side means
  // the stage has locked up.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               QuietLimit, outcome_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [3:0]              op;
    logic [5:0]              rs, imm;
    logic [eec_pkg::PcW-1:0] pc;
    eec_pkg::eec_res_t       none;
    none = '0;
    foreach (regs_model[i]) regs_model[i] = '0;
    foreach (dmem_model[i]) dmem_model[i] = '0;
    flags_model = '0;

    // Directed table. State carries from row to row, so the register values
    // noted in the comments are those left by the rows above.
    // Right after reset every register is zero: 0 + 0 sets only Z.
    directed_q.push_back('{encode(eec_pkg::OpAdd, 6'd0, 6'd0), 16'h0000, 1'b1,
                           outcome(16'h0000, 1'b0, 1'b1, 8'h00, 1'b0, FlagZ, 1'b0)});
    // All-ones word and pc: unused opcode, status held.
    directed_q.push_back('{encode(OpSpareHi, 6'd63, 6'd63), 16'hFFFF, 1'b1,
                           outcome(16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, FlagZ, 1'b1)});
    directed_q.push_back('{encode(OpSpareLo, 6'd0, 6'd0), 16'h0000, 1'b1,
                           outcome(16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, FlagZ, 1'b1)});
    // Largest immediate; MOVI leaves the status alone.
    directed_q.push_back('{encode(eec_pkg::OpMovi, 6'd1, 6'd63), 16'h1234, 1'b1,
                           outcome(16'h1234, 1'b0, 1'b1, 8'h3F, 1'b0, FlagZ, 1'b0)});
    // r1 = FC, then the same register on both sides with a carry.
    directed_q.push_back('{encode(eec_pkg::OpSal, 6'd1, 6'd2), 16'h0100, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpAdd, 6'd1, 6'd1), 16'h0101, 1'b0, none});
    // r3 = 80.
    directed_q.push_back('{encode(eec_pkg::OpMovi, 6'd3, 6'd32), 16'h0102, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpSal, 6'd3, 6'd2), 16'h0103, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpMovi, 6'd4, 6'd1), 16'h0104, 1'b0, none});
    // 80 - 1 overflows, then 7F + 7F overflows.
    directed_q.push_back('{encode(eec_pkg::OpSub, 6'd3, 6'd4), 16'h0105, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpAdd, 6'd3, 6'd3), 16'h0106, 1'b0, none});
    // F8 * F8, low byte only.
    directed_q.push_back('{encode(eec_pkg::OpMul, 6'd1, 6'd1), 16'h0107, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpAndi, 6'd3, 6'd42), 16'h0108, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpEor, 6'd3, 6'd1), 16'h0109, 1'b0, none});
    // Long shift left.
    directed_q.push_back('{encode(eec_pkg::OpSal, 6'd3, 6'd8), 16'h010A, 1'b0, none});
    // r6 = 80, then long arithmetic shifts of a negative and a positive value.
    directed_q.push_back('{encode(eec_pkg::OpMovi, 6'd6, 6'd32), 16'h010B, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpSal, 6'd6, 6'd2), 16'h010C, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpSar, 6'd6, 6'd63), 16'h010D, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpSar, 6'd4, 6'd8), 16'h010E, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpStr, 6'd6, 6'd63), 16'h010F, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpLdr, 6'd7, 6'd63), 16'h0110, 1'b0, none});
    // Load from a byte that was never written.
    directed_q.push_back('{encode(eec_pkg::OpLdr, 6'd8, 6'd0), 16'h0111, 1'b0, none});
    // Taken branch that wraps, then one not taken.
    directed_q.push_back('{encode(eec_pkg::OpBeqz, 6'd0, 6'd63), 16'hFFF0, 1'b0, none});
    directed_q.push_back('{encode(eec_pkg::OpBeqz, 6'd6, 6'd5), 16'h0113, 1'b0, none});
    // Register branch; the low byte FF is kept as it is.
    directed_q.push_back('{encode(eec_pkg::OpBr, 6'd1, 6'd6), 16'h0114, 1'b0, none});

    wait (rst_n);
    @(posedge clk);
    foreach (directed_q[i]) begin
      issue_instr(directed_q[i].word, directed_q[i].pc, directed_q[i].pinned,
                  directed_q[i].want);
    end

    // Random part. Operands lean toward a handful of low registers so that
    // results feed later instructions; shifts lean toward short amounts.
    for (int unsigned k = 0; k < RandomItems; k++) begin
      burst_mode = (k >= BurstFirst) && (k < BurstLast);
      if (k == HoldOffAt) sink_hold_req = 1'b1;
      op  = ($urandom_range(99) < 8) ? 4'($urandom_range(OpSpareHi, OpSpareLo))
                                     : 4'($urandom_range(eec_pkg::OpStr, eec_pkg::OpAdd));
      rs  = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      imm = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      if ((op == eec_pkg::OpSal || op == eec_pkg::OpSar) && $urandom_range(1)) begin
        imm = 6'($urandom_range(9));
      end
      pc  = ($urandom_range(9) == 0) ? 16'hFFC0 + 16'($urandom_range(63))
                                     : 16'($urandom_range(16'hFFFF));
      issue_instr(encode(op, rs, imm), pc, 1'b0, none);
    end
    burst_mode = 1'b0;
    in_valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    // A few more cycles so that any extra result beat would be seen.
    repeat (DrainCycles) @(posedge clk);

    $display("Executed %0d instructions (%0d from the directed table), checked %0d results.",
             issued_cnt, directed_q.size(), checked_cnt);
    $display("Branches redirected: %0d, unused opcodes: %0d, field mismatches: %0d.",
             taken_cnt, spare_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
